@@ hdl/spi_lcd_init_and_window_writer_assert.svh @@
// ----------------------------------------------------------------------------
// spi lcd writer assertion macros
// shared forms for the concurrent checks of the lcd byte stream writer
// ----------------------------------------------------------------------------
`ifndef SPI_LCD_INIT_AND_WINDOW_WRITER_ASSERT_SVH
`define SPI_LCD_INIT_AND_WINDOW_WRITER_ASSERT_SVH

// consequent checked in the same cycle
`define SLCDW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slcdw check failed");

// consequent checked in the next cycle
`define SLCDW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slcdw check failed");

`endif

@@ hdl/slcdw_pkg.sv @@
// ----------------------------------------------------------------------------
// slcdw_pkg
// types, codes and the microcode program of the lcd byte stream writer
// ----------------------------------------------------------------------------
`default_nettype none

package slcdw_pkg;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 13;
    localparam int PC_W       = 6;
    localparam int COUNT_W    = 25;

    // item ops
    localparam logic [1:0] OP_INIT = 2'd0;
    localparam logic [1:0] OP_WIN  = 2'd1;
    localparam logic [1:0] OP_PIX  = 2'd2;

    // result kinds
    localparam logic [2:0] KIND_CMD   = 3'd0;
    localparam logic [2:0] KIND_DATA  = 3'd1;
    localparam logic [2:0] KIND_DELAY = 3'd2;
    localparam logic [2:0] KIND_RST   = 3'd3;
    localparam logic [2:0] KIND_BL    = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PANEL_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PANEL_HEIGHT = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COL_OFFSET   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_OFFSET   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROTATION     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BGR_ORDER    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT       = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PIN_OPTIONS  = 4'd7;

    // register reset values
    localparam logic [12:0] RST_PANEL_WIDTH  = 13'd160;
    localparam logic [12:0] RST_PANEL_HEIGHT = 13'd80;
    localparam logic [11:0] RST_COL_OFFSET   = 12'd1;
    localparam logic [11:0] RST_ROW_OFFSET   = 12'd26;
    localparam logic [1:0]  RST_ROTATION     = 2'd3;
    localparam logic        RST_BGR_ORDER    = 1'b1;
    localparam logic        RST_INVERT       = 1'b1;
    localparam logic [1:0]  RST_PIN_OPTIONS  = 2'd3;

    // program entry points
    localparam logic [PC_W-1:0] PC_INIT = 6'd0;
    localparam logic [PC_W-1:0] PC_WIN  = 6'd51;
    localparam logic [PC_W-1:0] PC_PIX  = 6'd62;

    // panel command bytes
    localparam logic [7:0] CMD_SWRESET = 8'h01;
    localparam logic [7:0] CMD_SLPOUT  = 8'h11;
    localparam logic [7:0] CMD_INVOFF  = 8'h20;
    localparam logic [7:0] CMD_DISPON  = 8'h29;
    localparam logic [7:0] CMD_CASET   = 8'h2a;
    localparam logic [7:0] CMD_RASET   = 8'h2b;
    localparam logic [7:0] CMD_RAMWR   = 8'h2c;
    localparam logic [7:0] CMD_MADCTL  = 8'h36;
    localparam logic [7:0] CMD_COLMOD  = 8'h3a;
    localparam logic [7:0] CMD_GMCTRP  = 8'he0;
    localparam logic [7:0] CMD_GMCTRN  = 8'he1;
    localparam logic [7:0] COLOR_16BIT = 8'h55;
    localparam logic [7:0] DELAY_MS    = 8'd200;
    localparam logic [7:0] BGR_BIT     = 8'h08;
    localparam logic [7:0] ORIENT_0    = 8'hc0;
    localparam logic [7:0] ORIENT_1    = 8'h00;
    localparam logic [7:0] ORIENT_2    = 8'ha0;
    localparam logic [7:0] ORIENT_3    = 8'h60;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [15:0] x_start;
        logic signed [15:0] y_start;
        logic signed [15:0] x_end;
        logic signed [15:0] y_end;
        logic [15:0]        pixel;
    } in_item_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] value;
        logic       last;
        logic       window_done;
    } out_item_t;

    typedef enum logic [3:0] {
        SRC_IMM,
        SRC_INV,
        SRC_ORIENT,
        SRC_XS_HI,
        SRC_XS_LO,
        SRC_XE_HI,
        SRC_XE_LO,
        SRC_YS_HI,
        SRC_YS_LO,
        SRC_YE_HI,
        SRC_YE_LO,
        SRC_PIX_HI,
        SRC_PIX_LO
    } src_t;

    typedef enum logic [1:0] {
        COND_ALL,
        COND_LED,
        COND_RST
    } cond_t;

    typedef struct packed {
        logic last;
        logic last_no_led;
        logic wdone;
        logic load_cnt;
        logic dec_cnt;
    } flags_t;

    localparam flags_t F_NONE    = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
    localparam flags_t F_LAST    = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
    localparam flags_t F_LAST_NL = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
    localparam flags_t F_WIN_END = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
    localparam flags_t F_PIX_END = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

    typedef struct packed {
        logic [2:0] kind;
        src_t       src;
        logic [7:0] imm;
        cond_t      cond;
        flags_t     fl;
    } ctl_word_t;

    function automatic ctl_word_t cw(input logic [2:0] kind, input src_t src,
                                     input logic [7:0] imm, input cond_t cond,
                                     input flags_t fl);
        ctl_word_t w;
        w.kind = kind;
        w.src  = src;
        w.imm  = imm;
        w.cond = cond;
        w.fl   = fl;
        return w;
    endfunction

    // microcode program: init, window, pixel
    function automatic ctl_word_t rom_word(input logic [PC_W-1:0] addr);
        ctl_word_t w;
        unique case (addr)
            6'd0:  w = cw(KIND_BL,    SRC_IMM, 8'h00,       COND_LED, F_NONE);
            6'd1:  w = cw(KIND_RST,   SRC_IMM, 8'h01,       COND_RST, F_NONE);
            6'd2:  w = cw(KIND_RST,   SRC_IMM, 8'h00,       COND_RST, F_NONE);
            6'd3:  w = cw(KIND_RST,   SRC_IMM, 8'h01,       COND_RST, F_NONE);
            6'd4:  w = cw(KIND_DELAY, SRC_IMM, DELAY_MS,    COND_RST, F_NONE);
            6'd5:  w = cw(KIND_CMD,   SRC_IMM, CMD_SWRESET, COND_ALL, F_NONE);
            6'd6:  w = cw(KIND_DELAY, SRC_IMM, DELAY_MS,    COND_ALL, F_NONE);
            6'd7:  w = cw(KIND_CMD,   SRC_IMM, CMD_SLPOUT,  COND_ALL, F_NONE);
            6'd8:  w = cw(KIND_DELAY, SRC_IMM, DELAY_MS,    COND_ALL, F_NONE);
            6'd9:  w = cw(KIND_CMD,   SRC_INV, CMD_INVOFF,  COND_ALL, F_NONE);
            6'd10: w = cw(KIND_CMD,   SRC_IMM, CMD_COLMOD,  COND_ALL, F_NONE);
            6'd11: w = cw(KIND_DATA,  SRC_IMM, COLOR_16BIT, COND_ALL, F_NONE);
            6'd12: w = cw(KIND_CMD,   SRC_IMM, CMD_MADCTL,  COND_ALL, F_NONE);
            6'd13: w = cw(KIND_DATA,  SRC_ORIENT, 8'h00,    COND_ALL, F_NONE);
            6'd14: w = cw(KIND_CMD,   SRC_IMM, CMD_GMCTRP,  COND_ALL, F_NONE);
            6'd15: w = cw(KIND_DATA,  SRC_IMM, 8'h09,       COND_ALL, F_NONE);
            6'd16: w = cw(KIND_DATA,  SRC_IMM, 8'h16,       COND_ALL, F_NONE);
            6'd17: w = cw(KIND_DATA,  SRC_IMM, 8'h09,       COND_ALL, F_NONE);
            6'd18: w = cw(KIND_DATA,  SRC_IMM, 8'h20,       COND_ALL, F_NONE);
            6'd19: w = cw(KIND_DATA,  SRC_IMM, 8'h21,       COND_ALL, F_NONE);
            6'd20: w = cw(KIND_DATA,  SRC_IMM, 8'h1b,       COND_ALL, F_NONE);
            6'd21: w = cw(KIND_DATA,  SRC_IMM, 8'h13,       COND_ALL, F_NONE);
            6'd22: w = cw(KIND_DATA,  SRC_IMM, 8'h19,       COND_ALL, F_NONE);
            6'd23: w = cw(KIND_DATA,  SRC_IMM, 8'h17,       COND_ALL, F_NONE);
            6'd24: w = cw(KIND_DATA,  SRC_IMM, 8'h15,       COND_ALL, F_NONE);
            6'd25: w = cw(KIND_DATA,  SRC_IMM, 8'h1e,       COND_ALL, F_NONE);
            6'd26: w = cw(KIND_DATA,  SRC_IMM, 8'h2b,       COND_ALL, F_NONE);
            6'd27: w = cw(KIND_DATA,  SRC_IMM, 8'h04,       COND_ALL, F_NONE);
            6'd28: w = cw(KIND_DATA,  SRC_IMM, 8'h05,       COND_ALL, F_NONE);
            6'd29: w = cw(KIND_DATA,  SRC_IMM, 8'h02,       COND_ALL, F_NONE);
            6'd30: w = cw(KIND_DATA,  SRC_IMM, 8'h0e,       COND_ALL, F_NONE);
            6'd31: w = cw(KIND_CMD,   SRC_IMM, CMD_GMCTRN,  COND_ALL, F_NONE);
            6'd32: w = cw(KIND_DATA,  SRC_IMM, 8'h0b,       COND_ALL, F_NONE);
            6'd33: w = cw(KIND_DATA,  SRC_IMM, 8'h14,       COND_ALL, F_NONE);
            6'd34: w = cw(KIND_DATA,  SRC_IMM, 8'h08,       COND_ALL, F_NONE);
            6'd35: w = cw(KIND_DATA,  SRC_IMM, 8'h1e,       COND_ALL, F_NONE);
            6'd36: w = cw(KIND_DATA,  SRC_IMM, 8'h22,       COND_ALL, F_NONE);
            6'd37: w = cw(KIND_DATA,  SRC_IMM, 8'h1d,       COND_ALL, F_NONE);
            6'd38: w = cw(KIND_DATA,  SRC_IMM, 8'h18,       COND_ALL, F_NONE);
            6'd39: w = cw(KIND_DATA,  SRC_IMM, 8'h1e,       COND_ALL, F_NONE);
            6'd40: w = cw(KIND_DATA,  SRC_IMM, 8'h1b,       COND_ALL, F_NONE);
            6'd41: w = cw(KIND_DATA,  SRC_IMM, 8'h1a,       COND_ALL, F_NONE);
            6'd42: w = cw(KIND_DATA,  SRC_IMM, 8'h24,       COND_ALL, F_NONE);
            6'd43: w = cw(KIND_DATA,  SRC_IMM, 8'h2b,       COND_ALL, F_NONE);
            6'd44: w = cw(KIND_DATA,  SRC_IMM, 8'h06,       COND_ALL, F_NONE);
            6'd45: w = cw(KIND_DATA,  SRC_IMM, 8'h06,       COND_ALL, F_NONE);
            6'd46: w = cw(KIND_DATA,  SRC_IMM, 8'h02,       COND_ALL, F_NONE);
            6'd47: w = cw(KIND_DATA,  SRC_IMM, 8'h0f,       COND_ALL, F_NONE);
            6'd48: w = cw(KIND_CMD,   SRC_IMM, CMD_DISPON,  COND_ALL, F_NONE);
            6'd49: w = cw(KIND_DELAY, SRC_IMM, DELAY_MS,    COND_ALL, F_LAST_NL);
            6'd50: w = cw(KIND_BL,    SRC_IMM, 8'h01,       COND_LED, F_LAST);
            6'd51: w = cw(KIND_CMD,   SRC_IMM, CMD_CASET,   COND_ALL, F_NONE);
            6'd52: w = cw(KIND_DATA,  SRC_XS_HI, 8'h00,     COND_ALL, F_NONE);
            6'd53: w = cw(KIND_DATA,  SRC_XS_LO, 8'h00,     COND_ALL, F_NONE);
            6'd54: w = cw(KIND_DATA,  SRC_XE_HI, 8'h00,     COND_ALL, F_NONE);
            6'd55: w = cw(KIND_DATA,  SRC_XE_LO, 8'h00,     COND_ALL, F_NONE);
            6'd56: w = cw(KIND_CMD,   SRC_IMM, CMD_RASET,   COND_ALL, F_NONE);
            6'd57: w = cw(KIND_DATA,  SRC_YS_HI, 8'h00,     COND_ALL, F_NONE);
            6'd58: w = cw(KIND_DATA,  SRC_YS_LO, 8'h00,     COND_ALL, F_NONE);
            6'd59: w = cw(KIND_DATA,  SRC_YE_HI, 8'h00,     COND_ALL, F_NONE);
            6'd60: w = cw(KIND_DATA,  SRC_YE_LO, 8'h00,     COND_ALL, F_NONE);
            6'd61: w = cw(KIND_CMD,   SRC_IMM, CMD_RAMWR,   COND_ALL, F_WIN_END);
            6'd62: w = cw(KIND_DATA,  SRC_PIX_HI, 8'h00,    COND_ALL, F_NONE);
            6'd63: w = cw(KIND_DATA,  SRC_PIX_LO, 8'h00,    COND_ALL, F_PIX_END);
            default: w = cw(KIND_CMD, SRC_IMM, 8'h00,       COND_ALL, F_LAST);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

@@ hdl/spi_lcd_init_and_window_writer.sv @@
// ----------------------------------------------------------------------------
// spi_lcd_init_and_window_writer
// command and data byte stream generator for a small spi color lcd panel
// ----------------------------------------------------------------------------
// One item at a time runs a short microcode program, one control word per
// clock from a 64-step table: init runs its whole program, or ends at its final
// delay when the backlight pin is absent, a window its address steps, a pixel
// its two bytes. The step counter is the pacing unit: each step that emits waits
// for the output register to be free, so a stalled output stretches the run.
// The next item is taken in the same cycle that the final result of the
// current one is loaded. Rejected windows, pixels with no open window and
// unused ops are taken and produce nothing.
`default_nettype none

module spi_lcd_init_and_window_writer (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  slcdw_pkg::in_item_t                  in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output slcdw_pkg::out_item_t                 out_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [slcdw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [slcdw_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import slcdw_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    // configuration
    logic [12:0] width_reg;
    logic [12:0] height_reg;
    logic [11:0] col_off_reg;
    logic [11:0] row_off_reg;
    logic [1:0]  rotation_reg;
    logic        bgr_reg;
    logic        invert_reg;
    logic [1:0]  pins_reg;

    // sequencer
    state_t            state_reg, state_next;
    logic [PC_W-1:0]   pc_reg, pc_next;
    in_item_t          item_reg;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_data_reg, out_data_next;

    ctl_word_t   word;
    logic        running;
    logic        led_pin;
    logic        rst_pin;
    logic        cond_ok;
    logic        out_free;
    logic        step_go;
    logic        fire;
    logic        fin_now;
    logic        accept;
    logic        start;
    logic [PC_W-1:0] start_pc;
    logic        win_ok;
    logic        pix_ok;
    logic [7:0]  orient;
    logic [15:0] addr_opnd;
    logic [15:0] addr_off;
    logic [15:0] addr_sum;
    logic [7:0]  value;
    logic [12:0] win_w;
    logic [12:0] win_h;
    logic [25:0] win_prod;
    logic [COUNT_W-1:0] win_count;

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= RST_PANEL_WIDTH;
            height_reg   <= RST_PANEL_HEIGHT;
            col_off_reg  <= RST_COL_OFFSET;
            row_off_reg  <= RST_ROW_OFFSET;
            rotation_reg <= RST_ROTATION;
            bgr_reg      <= RST_BGR_ORDER;
            invert_reg   <= RST_INVERT;
            pins_reg     <= RST_PIN_OPTIONS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PANEL_WIDTH:  width_reg    <= cfg_data[12:0];
                REG_PANEL_HEIGHT: height_reg   <= cfg_data[12:0];
                REG_COL_OFFSET:   col_off_reg  <= cfg_data[11:0];
                REG_ROW_OFFSET:   row_off_reg  <= cfg_data[11:0];
                REG_ROTATION:     rotation_reg <= cfg_data[1:0];
                REG_BGR_ORDER:    bgr_reg      <= cfg_data[0];
                REG_INVERT:       invert_reg   <= cfg_data[0];
                REG_PIN_OPTIONS:  pins_reg     <= cfg_data[1:0];
                default:          ;
            endcase
        end
    end

    assign word    = rom_word(pc_reg);
    assign running = (state_reg == ST_RUN);
    assign led_pin = pins_reg[1];
    assign rst_pin = pins_reg[0];

    always_comb
    begin
        unique case (word.cond)
            COND_ALL: cond_ok = 1'b1;
            COND_LED: cond_ok = led_pin;
            COND_RST: cond_ok = rst_pin;
            default:  cond_ok = 1'b0;
        endcase
    end

    // a step whose pin is absent passes without emitting
    assign out_free = !out_valid_reg || !out_stall;
    assign step_go  = running && (!cond_ok || out_free);
    assign fire     = running && cond_ok && out_free;
    assign fin_now  = step_go && (word.fl.last || (word.fl.last_no_led && !led_pin));

    assign in_stall = running && !fin_now;
    assign accept   = in_valid && !in_stall;

    // window bounds check on the incoming item
    assign win_ok = !(in_data.x_end < in_data.x_start) &&
                    !(in_data.y_end < in_data.y_start) &&
                    !in_data.x_start[15] && !in_data.y_start[15] &&
                    ($unsigned(in_data.x_end) < {3'b000, width_reg}) &&
                    ($unsigned(in_data.y_end) < {3'b000, height_reg});

    // count as it stands after this cycle's step
    always_comb
    begin
        if (fire && word.fl.load_cnt)
            pix_ok = 1'b1;
        else if (fire && word.fl.dec_cnt)
            pix_ok = (count_reg != COUNT_W'(1));
        else
            pix_ok = (count_reg != '0);
    end

    always_comb
    begin
        unique case (in_data.op)
            OP_INIT:
            begin
                start    = 1'b1;
                start_pc = PC_INIT;
            end
            OP_WIN:
            begin
                start    = win_ok;
                start_pc = PC_WIN;
            end
            OP_PIX:
            begin
                start    = pix_ok;
                start_pc = PC_PIX;
            end
            default:
            begin
                start    = 1'b0;
                start_pc = PC_INIT;
            end
        endcase
    end

    always_comb
    begin
        unique case (rotation_reg)
            2'd0:    orient = ORIENT_0;
            2'd1:    orient = ORIENT_1;
            2'd2:    orient = ORIENT_2;
            default: orient = ORIENT_3;
        endcase
        if (bgr_reg)
            orient = orient | BGR_BIT;
    end

    // address bytes: corner plus offset, kept to 16 bits
    always_comb
    begin
        unique case (word.src)
            SRC_XS_HI, SRC_XS_LO:
            begin
                addr_opnd = item_reg.x_start;
                addr_off  = {4'd0, col_off_reg};
            end
            SRC_XE_HI, SRC_XE_LO:
            begin
                addr_opnd = item_reg.x_end;
                addr_off  = {4'd0, col_off_reg};
            end
            SRC_YS_HI, SRC_YS_LO:
            begin
                addr_opnd = item_reg.y_start;
                addr_off  = {4'd0, row_off_reg};
            end
            default:
            begin
                addr_opnd = item_reg.y_end;
                addr_off  = {4'd0, row_off_reg};
            end
        endcase
    end

    assign addr_sum = addr_opnd + addr_off;

    always_comb
    begin
        unique case (word.src)
            SRC_IMM:    value = word.imm;
            SRC_INV:    value = word.imm | {7'd0, invert_reg};
            SRC_ORIENT: value = orient;
            SRC_XS_HI, SRC_XE_HI, SRC_YS_HI, SRC_YE_HI:
                        value = addr_sum[15:8];
            SRC_XS_LO, SRC_XE_LO, SRC_YS_LO, SRC_YE_LO:
                        value = addr_sum[7:0];
            SRC_PIX_HI: value = item_reg.pixel[15:8];
            SRC_PIX_LO: value = item_reg.pixel[7:0];
            default:    value = word.imm;
        endcase
    end

    // window size from the held item; both sides fit 13 bits once accepted
    assign win_w     = item_reg.x_end[12:0] - item_reg.x_start[12:0] + 13'd1;
    assign win_h     = item_reg.y_end[12:0] - item_reg.y_start[12:0] + 13'd1;
    assign win_prod  = {13'd0, win_w} * {13'd0, win_h};
    assign win_count = win_prod[25] ? {COUNT_W{1'b1}} : win_prod[COUNT_W-1:0];

    always_comb
    begin
        count_next = count_reg;
        if (fire && word.fl.load_cnt)
            count_next = win_count;
        else if (fire && word.fl.dec_cnt)
            count_next = count_reg - COUNT_W'(1);
        if (accept && (in_data.op == OP_INIT))
            count_next = '0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (fire)
        begin
            out_valid_next            = 1'b1;
            out_data_next.kind        = word.kind;
            out_data_next.value       = value;
            out_data_next.last        = word.fl.last ||
                                        (word.fl.last_no_led && !led_pin);
            out_data_next.window_done = word.fl.wdone &&
                                        (count_reg == COUNT_W'(1));
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        if (accept && start)
        begin
            state_next = ST_RUN;
            pc_next    = start_pc;
        end
        else if (step_go)
        begin
            if (fin_now)
                state_next = ST_IDLE;
            else
                pc_next = pc_reg + PC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= PC_INIT;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (accept)
            item_reg <= in_data;
    end

endmodule

`default_nettype wire

@@ hdl/slcdw_checker.sv @@
// ----------------------------------------------------------------------------
// slcdw_checker
// port-level checks on the lcd byte stream writer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "spi_lcd_init_and_window_writer_assert.svh"

module slcdw_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input slcdw_pkg::out_item_t  out_data
);
    import slcdw_pkg::*;

    // a held result does not move
    `SLCDW_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

    // a held result short of the run's final one keeps the input closed
    `SLCDW_ASSERT_NOW(a_busy_mid_run, clk, rst_n, out_valid && out_stall && !out_data.last, in_stall)

    // results start appearing only while a run is in progress
    `SLCDW_ASSERT_NOW(a_rise_in_run, clk, rst_n, $rose(out_valid), $past(in_stall))

    // end of window only on the final data byte of a pixel
    `SLCDW_ASSERT_NOW(a_wdone_last, clk, rst_n, out_valid && out_data.window_done, out_data.last && (out_data.kind == KIND_DATA))

endmodule

bind spi_lcd_init_and_window_writer slcdw_checker u_slcdw_checker (.*);

`default_nettype wire
